@@ hw/rtl/swoq_pkg.sv @@
package swoq_pkg;

  localparam int QUEUE_DEPTH = 512;
  localparam int VALUE_BITS  = 26;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int LC_W        = 5;
  localparam int TGT_W       = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int PADDR_W     = 3;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [LC_W-1:0] LETTER_COUNT_RST = LC_W'(26);
  localparam logic            REG_LETTER_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]            command;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] window_or;
    logic                  is_empty;
    logic                  all_present;
    logic                  push_dropped;
  } out_t;

endpackage

@@ hw/rtl/swoq_ram.sv @@
module swoq_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/swoq_cfg.sv @@
module swoq_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swoq_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [swoq_pkg::LC_W-1:0]           letter_count_o
);
  import swoq_pkg::*;

  logic [LC_W-1:0] letter_count_q, letter_count_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_LETTER_COUNT);

  always_comb begin
    letter_count_d = letter_count_q;
    if (wr_en) begin
      letter_count_d = pwdata[LC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_count_q <= LETTER_COUNT_RST;
    end else begin
      letter_count_q <= letter_count_d;
    end
  end

  assign prdata = (paddr[2] == REG_LETTER_COUNT) ? 32'(letter_count_q) : 32'd0;
  assign letter_count_o = letter_count_q;

endmodule

@@ hw/rtl/sliding_window_or_queue.sv @@
// Queue of bit masks that reports the OR of every word it holds.
// Command channel: a word (command, value) is taken when start is high and
// busy is low. busy stays high while the sequencer works on it.
// Result channel: done_o is high for exactly one cycle with result_o; the
// receiver cannot stall, so each result must be taken in that cycle.
// Push, clear, no-op, a pop on an empty queue and a pop from a front stack
// of one entry go straight to the output state. A pop that leaves the front
// stack nonempty rereads the new front top from the front RAM. A pop with
// an empty front stack first moves the n back entries over (back RAM read,
// then front RAM write of the prefix OR), plus the reread when entries
// remain. busy drops when done_o is high, so the next word can follow.
// Config: APB register letter_count at address 0, written only while idle
// by the user; the block does not enforce it. Reset empties both stacks
// and sets letter_count to 26; RAM contents are not cleared, only entries
// below the counts are ever used.
module sliding_window_or_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  swoq_pkg::in_t                 item_i,
  output logic                          done_o,
  output swoq_pkg::out_t                result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swoq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swoq_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_XRD  = 3'd1;
  localparam logic [2:0] ST_XWR  = 3'd2;
  localparam logic [2:0] ST_FRD  = 3'd3;
  localparam logic [2:0] ST_FLD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      bc_q, bc_d, fc_q, fc_d;
  logic [VALUE_BITS-1:0] bro_q, bro_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] top_q, top_d;
  logic                  dropped_q, dropped_d;
  logic                  done_q, done_d;
  out_t                  res_q, res_d;

  logic [LC_W-1:0]       letter_count;
  logic                  bwe, fwe;
  logic [VALUE_BITS-1:0] brd, frd, fwdata, prefix;
  logic [ADDR_W-1:0]     braddr, fraddr;
  logic [CNT_W:0]        fill;
  logic [VALUE_BITS-1:0] total;
  logic [TGT_W-1:0]      target;

  swoq_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .letter_count_o (letter_count)
  );

  swoq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(VALUE_BITS)) u_back_ram (
    .clk_i,
    .we_i    (bwe),
    .waddr_i (bc_q[ADDR_W-1:0]),
    .wdata_i (item_i.value),
    .raddr_i (braddr),
    .rdata_o (brd)
  );

  swoq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(VALUE_BITS)) u_front_ram (
    .clk_i,
    .we_i    (fwe),
    .waddr_i (fc_q[ADDR_W-1:0]),
    .wdata_i (fwdata),
    .raddr_i (fraddr),
    .rdata_o (frd)
  );

  assign braddr = ADDR_W'(bc_q - CNT_W'(1));
  assign fraddr = ADDR_W'(fc_q - CNT_W'(1));
  assign prefix = acc_q | brd;
  assign fwdata = prefix;
  assign fill   = {1'b0, bc_q} + {1'b0, fc_q};
  assign busy   = (state_q != ST_IDLE);

  assign total  = ((fc_q != '0) ? top_q : '0) | ((bc_q != '0) ? bro_q : '0);
  assign target = (TGT_W'(1) << letter_count) - TGT_W'(1);

  always_comb begin
    state_d   = state_q;
    bc_d      = bc_q;
    fc_d      = fc_q;
    bro_d     = bro_q;
    acc_d     = acc_q;
    top_d     = top_q;
    dropped_d = dropped_q;
    done_d    = 1'b0;
    res_d     = res_q;
    bwe       = 1'b0;
    fwe       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          dropped_d = 1'b0;
          state_d   = ST_OUT;
          case (item_i.command)
            CMD_PUSH: begin
              if (fill >= (CNT_W+1)'(QUEUE_DEPTH)) begin
                dropped_d = 1'b1;
              end else begin
                bwe   = 1'b1;
                bc_d  = bc_q + CNT_W'(1);
                bro_d = bro_q | item_i.value;
              end
            end
            CMD_POP: begin
              if (fc_q != '0) begin
                fc_d = fc_q - CNT_W'(1);
                if (fc_q > CNT_W'(1)) begin
                  state_d = ST_FRD;
                end
              end else if (bc_q != '0) begin
                acc_d   = '0;
                state_d = ST_XRD;
              end
            end
            CMD_CLEAR: begin
              bc_d  = '0;
              fc_d  = '0;
              bro_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_XRD: begin
        bc_d    = bc_q - CNT_W'(1);
        state_d = ST_XWR;
      end
      ST_XWR: begin
        fwe   = 1'b1;
        acc_d = prefix;
        if (bc_q == '0) begin
          // last entry moved and popped at once
          bro_d   = '0;
          state_d = (fc_q != '0) ? ST_FRD : ST_OUT;
        end else begin
          fc_d    = fc_q + CNT_W'(1);
          state_d = ST_XRD;
        end
      end
      ST_FRD: begin
        state_d = ST_FLD;
      end
      ST_FLD: begin
        top_d   = frd;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_d.window_or    = total;
        res_d.is_empty     = (bc_q == '0) && (fc_q == '0);
        res_d.all_present  = (TGT_W'(total) == target);
        res_d.push_dropped = dropped_q;
        done_d             = 1'b1;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bc_q    <= '0;
      fc_q    <= '0;
      bro_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bc_q    <= bc_d;
      fc_q    <= fc_d;
      bro_q   <= bro_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    top_q     <= top_d;
    dropped_q <= dropped_d;
    res_q     <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= (CNT_W+1)'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.is_empty) |-> (result_o.window_or == '0))
    else $error("empty queue with nonzero OR");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.push_dropped) |-> !result_o.is_empty)
    else $error("dropped push on a queue that is not full");

  a_xfer_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_XRD) |-> (bc_q != '0))
    else $error("transfer read with empty back stack");

endmodule

@@ tb/sliding_window_or_queue_tb.sv @@
`timescale 1ns / 1ps

module sliding_window_or_queue_tb;
  import swoq_pkg::*;

  localparam logic [1:0]            CMD_NOP       = 2'd3;
  localparam logic [VALUE_BITS-1:0] ALL_ONES      = {VALUE_BITS{1'b1}};
  localparam int                    SETTLE_CYCLES = 8;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  in_t                 item_i  = '0;
  logic                done_o;
  out_t                result_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  sliding_window_or_queue DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // two-stack mirror of the block
  logic [VALUE_BITS-1:0] back_vals [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] front_pfx [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] back_or   = '0;
  int                    back_cnt  = 0;
  int                    front_cnt = 0;
  logic [LC_W-1:0]       letters   = LETTER_COUNT_RST;

  out_t expected_status_q [$];
  int   mismatch_cnt = 0;
  int   idle_pct     = 0;

  function automatic out_t predict_window_status(input in_t w);
    out_t                  r;
    logic [VALUE_BITS-1:0] below;
    logic [63:0]           tgt;
    r = '0;
    case (w.command)
      CMD_PUSH: begin
        if (back_cnt + front_cnt >= QUEUE_DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          back_vals[back_cnt] = w.value;
          back_cnt++;
          back_or |= w.value;
        end
      end
      CMD_POP: begin
        if (front_cnt == 0) begin
          while (back_cnt > 0) begin
            below = (front_cnt > 0) ? front_pfx[front_cnt-1] : '0;
            back_cnt--;
            front_pfx[front_cnt] = below | back_vals[back_cnt];
            front_cnt++;
          end
          back_or = '0;
        end
        if (front_cnt > 0) front_cnt--;
      end
      CMD_CLEAR: begin
        back_cnt  = 0;
        front_cnt = 0;
        back_or   = '0;
      end
      default: ;
    endcase
    r.window_or = ((front_cnt > 0) ? front_pfx[front_cnt-1] : '0) |
                  ((back_cnt > 0) ? back_or : '0);
    r.is_empty    = (back_cnt == 0) && (front_cnt == 0);
    tgt           = (64'd1 << letters) - 64'd1;
    r.all_present = (64'(r.window_or) == tgt);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_status_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word or=%h empty=%b all=%b drop=%b",
                                result_o.window_or, result_o.is_empty,
                                result_o.all_present, result_o.push_dropped));
      end else begin
        exp_r = expected_status_q.pop_front();
        if (result_o.window_or !== exp_r.window_or ||
            result_o.is_empty !== exp_r.is_empty ||
            result_o.all_present !== exp_r.all_present ||
            result_o.push_dropped !== exp_r.push_dropped) begin
          note_mismatch($sformatf(
            "exp or=%h empty=%b all=%b drop=%b, got or=%h empty=%b all=%b drop=%b",
            exp_r.window_or, exp_r.is_empty, exp_r.all_present, exp_r.push_dropped,
            result_o.window_or, result_o.is_empty, result_o.all_present,
            result_o.push_dropped));
        end
      end
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [VALUE_BITS-1:0] val);
    in_t w;
    w.command = cmd;
    w.value   = val;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_status_q.push_back(predict_window_status(w));
  endtask

  task automatic settle_queue();
    start <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_letters(input logic [LC_W-1:0] lc);
    logic [31:0] wd;
    settle_queue();
    wd        = $urandom();
    wd[LC_W-1:0] = lc;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_LETTER_COUNT);
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    letters = lc;
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(lc))
      note_mismatch($sformatf("letter_count read exp=%h got=%h", 32'(lc), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [VALUE_BITS-1:0] low_mask(input logic [LC_W-1:0] lc);
    return VALUE_BITS'((64'd1 << lc) - 64'd1);
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_word(CMD_PUSH, '0);
    send_word(CMD_PUSH, ALL_ONES);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_NOP, ALL_ONES);
    send_word(CMD_PUSH, VALUE_BITS'(1));
    send_word(CMD_PUSH, VALUE_BITS'(1) << (VALUE_BITS - 1));
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, 26'h1555555);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, 26'h2AAAAAA);
    send_word(CMD_PUSH, 26'h1555555);
    send_word(CMD_NOP, '0);
    send_word(CMD_CLEAR, ALL_ONES);
    send_word(CMD_CLEAR, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, 26'h0F0F0F0);
    send_word(CMD_PUSH, 26'h30F0F0F);
    send_word(CMD_POP, '0);
    send_word(CMD_CLEAR, '0);
  endtask

  task automatic test_letter_count();
    logic [LC_W-1:0] lc_list [7];
    lc_list = '{5'd0, 5'd1, 5'd5, 5'd25, 5'd27, 5'd31, 5'd26};
    foreach (lc_list[i]) begin
      write_letters(lc_list[i]);
      send_word(CMD_POP, '0);
      send_word(CMD_PUSH, low_mask(lc_list[i]));
      send_word(CMD_PUSH, VALUE_BITS'(64'd1 << lc_list[i]));
      send_word(CMD_CLEAR, '0);
    end
  endtask

  task automatic test_full_queue();
    write_letters(LETTER_COUNT_RST);
    idle_pct = 0;
    send_word(CMD_CLEAR, '0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_word(CMD_PUSH, VALUE_BITS'(1) << (i % VALUE_BITS));
    repeat (3) send_word(CMD_PUSH, VALUE_BITS'($urandom()));
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, VALUE_BITS'($urandom()));
    send_word(CMD_PUSH, VALUE_BITS'($urandom()));
    repeat (30) send_word(CMD_POP, '0);
    send_word(CMD_CLEAR, '0);
  endtask

  task automatic test_random(input int idle, input int n, input logic [LC_W-1:0] lc);
    int                    r;
    int                    top;
    logic [1:0]            cmd;
    logic [VALUE_BITS-1:0] val;
    write_letters(lc);
    idle_pct = idle;
    top = (lc >= 1 && lc <= VALUE_BITS) ? lc - 1 : VALUE_BITS - 1;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 50) cmd = CMD_PUSH;
      else if (r < 90) cmd = CMD_POP;
      else if (r < 95) cmd = CMD_CLEAR;
      else cmd = CMD_NOP;
      r = $urandom_range(9);
      if (r < 6) val = VALUE_BITS'(1) << $urandom_range(top);
      else if (r < 9) val = VALUE_BITS'($urandom());
      else val = low_mask(lc);
      send_word(cmd, val);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_letter_count();
    test_full_queue();
    test_random(0, 200, LETTER_COUNT_RST);
    test_random(73, 180, LC_W'($urandom_range(1, VALUE_BITS)));
    test_random(25, 150, LC_W'($urandom_range(31)));
    settle_queue();
    if (mismatch_cnt == 0 && expected_status_q.size() == 0) begin
      $display("sliding_window_or_queue_tb OK");
    end else begin
      $display("sliding_window_or_queue_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("sliding_window_or_queue_tb NOT OK");
    $finish;
  end

endmodule
